/* design/i2r_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and constants for the integer to radix digits block
// Digit stack geometry, radix limits, sequencer states and the digit
// character lookup.
// ----------------------------------------------------------------------------
package i2r_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int RADIX_W         = 6;
   localparam int STACK_DEPTH     = 64;
   localparam int ADDR_W          = $clog2(STACK_DEPTH);
   localparam int COUNT_W         = ADDR_W + 1;
   localparam int CHAR_W          = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_TEN = RADIX_W'(10);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;  // 'a'
   localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h7a;  // 'z'
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_READ,
      ST_LOAD,
      ST_OUT
   } state_type;

   // digit stack port bundle
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [RADIX_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } stack_ctl_type;

   // 0-9 then a-z; anything above 35 saturates to 'z'
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < RADIX_TEN) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else if (d < RADIX_MAX) begin
         c = CHAR_A + CHAR_W'(d - RADIX_TEN);
      end else begin
         c = CHAR_Z;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* design/i2r_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_divider: bit-serial restoring divider
// Divides a VALUE_WIDTH-bit dividend by a small radix, one quotient bit per
// cycle. Pulses done when quotient and remainder are valid.
// ----------------------------------------------------------------------------
module i2r_divider #(
   parameter int VALUE_WIDTH = i2r_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [VALUE_WIDTH-1:0]      dividend,
   input  wire logic [i2r_pkg::RADIX_W-1:0] divisor,
   output logic                             done,
   output logic [VALUE_WIDTH-1:0]           quotient,
   output logic [i2r_pkg::RADIX_W-1:0]      remainder
);
   import i2r_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W:0]       rem_sh;
   logic [RADIX_W:0]       rem_sub;
   logic                   ge;

   assign rem_sh  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign ge      = rem_sh >= {1'b0, divisor};
   assign rem_sub = rem_sh - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

/* design/i2r_stack.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_stack: digit stack memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module i2r_stack (
   input  wire logic                        clock,
   input  wire i2r_pkg::stack_ctl_type      ctl,
   output logic [i2r_pkg::RADIX_W-1:0]      rd_data
);
   import i2r_pkg::*;

   logic [RADIX_W-1:0] mem [STACK_DEPTH];
   logic [RADIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/int64_to_radix_digits.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_to_radix_digits: integer to ASCII digit string converter
// Converts a value to lower-case digits in radix 2..36, most significant
// first, with a leading '-' for negative values in signed radix-ten mode.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                  | meaning
//  --------+-----------+----------------------------------------+-------------------
//  req     | in        | req_valid/ready, req_func, req_value_in, | one value to
//          |           | req_radix                              | convert
//  rsp     | out       | rsp_valid/ready, rsp_char_code, rsp_last | one character
//
//  Steps: each digit costs one pass of the bit-serial divider, plus a start
//  state and a write-back to the stack. Each character then passes through
//  the stack read, lookup and output states; the output waits on rsp_ready.
//  req_ready is high only when idle; the divider is the limiting unit.
//  Reset is synchronous and clears the sequencer; the stack needs no clear.
//  A stall on rsp holds the current character in its output register.
//
module int64_to_radix_digits #(
   parameter int VALUE_WIDTH = i2r_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [63:0]                  req_value_in,
   input  wire logic [i2r_pkg::RADIX_W-1:0]  req_radix,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [i2r_pkg::CHAR_W-1:0]        rsp_char_code,
   output logic                              rsp_last
);
   import i2r_pkg::*;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;     // remaining quotient
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   minus_ff, minus_in;   // '-' still to be sent
   logic [COUNT_W-1:0]     count_ff, count_in;   // digits on the stack
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   last_ff, last_in;

   // input side: clamp radix, take magnitude when signed radix ten
   logic [VALUE_WIDTH-1:0] req_val;
   logic [RADIX_W-1:0]     req_rad;
   logic                   req_neg;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [RADIX_W-1:0]     div_rem;

   stack_ctl_type          stk_ctl;
   logic [RADIX_W-1:0]     stk_rd_data;

   assign req_val = req_value_in[VALUE_WIDTH-1:0];

   always_comb begin
      if (req_radix < RADIX_MIN) begin
         req_rad = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         req_rad = RADIX_MAX;
      end else begin
         req_rad = req_radix;
      end
   end

   assign req_neg = req_func && (req_rad == RADIX_TEN) && req_val[VALUE_WIDTH-1];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      quot_in   = quot_ff;
      radix_in  = radix_ff;
      minus_in  = minus_ff;
      count_in  = count_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      stk_ctl   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               quot_in  = req_neg ? (VALUE_WIDTH'(0) - req_val) : req_val;
               radix_in = req_rad;
               minus_in = req_neg;
               count_in = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               stk_ctl.wr_en   = 1'b1;
               stk_ctl.wr_addr = count_ff[ADDR_W-1:0];
               stk_ctl.wr_data = div_rem;
               quot_in         = div_quo;
               count_in        = count_ff + COUNT_W'(1);
               if ((div_quo != '0) && (count_ff != COUNT_W'(STACK_DEPTH - 1))) begin
                  state_in = ST_DIV_START;
               end else if (minus_ff) begin
                  // at least one digit follows the sign
                  char_in  = CHAR_MINUS;
                  last_in  = 1'b0;
                  minus_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            stk_ctl.rd_en   = 1'b1;
            stk_ctl.rd_addr = ADDR_W'(count_ff - COUNT_W'(1));
            count_in        = count_ff - COUNT_W'(1);
            state_in        = ST_LOAD;
         end
         ST_LOAD: begin
            char_in  = digit_char(stk_rd_data);
            last_in  = (count_ff == '0);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = last_ff ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         minus_ff <= 1'b0;
         count_ff <= '0;
         quot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         minus_ff <= minus_in;
         count_ff <= count_in;
         quot_ff  <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff <= radix_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   i2r_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (quot_ff),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   i2r_stack u_stack (
      .clock   (clock),
      .ctl     (stk_ctl),
      .rd_data (stk_rd_data)
   );

   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire
